// ===== design/ghal_pkg.sv =====
// ghal_pkg: shared constants, codes and request structs of the generational handle allocator
// no dependencies; used by every module of the block
package ghal_pkg;

  localparam int unsigned SLOTS = 256;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned GEN_W = 16;
  localparam int unsigned OP_W  = 3;
  localparam int unsigned ST_W  = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_REMOVE = 3'd1,
    OP_CHECK  = 3'd2,
    OP_FIRST  = 3'd3,
    OP_NEXT   = 3'd4,
    OP_PREV   = 3'd5
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK           = 3'd0,
    ST_GEN_MISMATCH = 3'd1,
    ST_REMOVED      = 3'd2,
    ST_FULL         = 3'd3,
    ST_NONE         = 3'd4,
    ST_INVALID      = 3'd5
  } status_e;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } result_t;

  // slot table requests, one read and one write port
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    logic [GEN_W-1:0] wr_gen;
    logic             wr_rem;
  } tbl_req_t;

  // free queue requests
  typedef struct packed {
    logic             rd_en;
    logic             pop;
    logic             push;
    logic [IDX_W-1:0] push_idx;
    logic [GEN_W-1:0] push_gen;
  } fifo_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
  } fifo_entry_t;

endpackage

// ===== design/generational_handle_allocator.sv =====
// generational_handle_allocator: top level, sequencer over the slot table and free queue
// depends on ghal_pkg, ghal_slot_table, ghal_free_fifo
//
// channel   dir  signals                 tdata fields, lsb first
// s (in)    in   s_tvalid/tready/tdata   operation[2:0] slot_index[10:3] generation[26:11]
// m (out)   out  m_tvalid/tready/tdata   status[2:0] handle_index[10:3] handle_generation[26:11]
//
// one transaction at a time: allocate (via S_POP when a freed slot is reused), remove and
// check (via S_CHECK for an index in use) go on to S_RESP, which loads the output register;
// first, next and previous stream reads through the slot memory one slot per cycle, at most the slots in use
// the slot and queue memories have registered reads
// reset clears the slot count and the queue pointers; memories hold, and every slot
// is written when first allocated, before it can be read
// a finished result waits in the output register while the next transaction is taken
module generational_handle_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [ghal_pkg::DATA_W-1:0] s_tdata_i,   // operation, slot_index, generation
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [ghal_pkg::DATA_W-1:0] m_tdata_o    // status, handle_index, handle_generation
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_POP   = 5'b00010,
    S_CHECK = 5'b00100,
    S_SCAN  = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  ghal_pkg::op_e                 op_q, op_d;
  logic [ghal_pkg::IDX_W-1:0]    idx_q, idx_d;
  logic [ghal_pkg::GEN_W-1:0]    gen_q, gen_d;
  logic [ghal_pkg::CNT_W-1:0]    used_q, used_d;
  logic [ghal_pkg::IDX_W-1:0]    ptr_q, ptr_d;
  logic [ghal_pkg::CNT_W-1:0]    left_q, left_d;
  logic                          up_q, up_d;
  logic                          vld_q, vld_d;
  logic [ghal_pkg::IDX_W-1:0]    chk_q, chk_d;
  ghal_pkg::result_t             res_q, res_d;
  logic                          m_tvalid_q, m_tvalid_d;
  logic [ghal_pkg::DATA_W-1:0]   m_tdata_q, m_tdata_d;

  ghal_pkg::tbl_req_t            tbl_req;
  ghal_pkg::fifo_req_t           fifo_req;
  logic [ghal_pkg::GEN_W-1:0]    tbl_gen;
  logic                          tbl_rem;
  ghal_pkg::fifo_entry_t         fifo_entry;
  logic [ghal_pkg::CNT_W-1:0]    fifo_count;

  // input fields
  logic [ghal_pkg::OP_W-1:0]     in_op;
  logic [ghal_pkg::IDX_W-1:0]    in_idx;
  logic [ghal_pkg::GEN_W-1:0]    in_gen;
  logic                          accept;
  logic                          out_free;
  logic                          in_lt;
  logic [ghal_pkg::CNT_W-1:0]    idx_inc;
  logic [ghal_pkg::IDX_W-1:0]    last;
  logic [ghal_pkg::IDX_W-1:0]    ptr_step;

  assign in_op  = s_tdata_i[2:0];
  assign in_idx = s_tdata_i[10:3];
  assign in_gen = s_tdata_i[26:11];

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign out_free   = !m_tvalid_q || m_tready_i;

  assign in_lt   = {1'b0, in_idx} < used_q;
  assign idx_inc = {1'b0, in_idx} + 1'b1;
  assign last    = used_q[ghal_pkg::IDX_W-1:0] - 1'b1;
  // scan step with wraparound over the used slots
  assign ptr_step = up_q ? ((ptr_q == last) ? '0 : ptr_q + 1'b1)
                         : ((ptr_q == '0) ? last : ptr_q - 1'b1);

  ghal_slot_table u_table (
    .clk_i    (clk_i),
    .req_i    (tbl_req),
    .rd_gen_o (tbl_gen),
    .rem_o    (tbl_rem)
  );

  ghal_free_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (fifo_req),
    .rd_entry_o (fifo_entry),
    .count_o    (fifo_count)
  );

  // sequencer; memory writes land before the next transaction can read,
  // so no forwarding is needed
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    idx_d      = idx_q;
    gen_d      = gen_q;
    used_d     = used_q;
    ptr_d      = ptr_q;
    left_d     = left_q;
    up_d       = up_q;
    vld_d      = 1'b0;
    chk_d      = chk_q;
    res_d      = res_q;
    m_tvalid_d = m_tvalid_q && !m_tready_i;
    m_tdata_d  = m_tdata_q;
    tbl_req    = '0;
    fifo_req   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = ghal_pkg::op_e'(in_op);
          idx_d = in_idx;
          gen_d = in_gen;
          res_d = '{status: ghal_pkg::ST_INVALID, idx: '0, gen: '0};
          state_d = S_RESP;
          unique case (in_op)
            ghal_pkg::OP_ALLOC: begin
              if (fifo_count != '0) begin
                fifo_req.rd_en = 1'b1;
                state_d = S_POP;
              end else if (used_q != ghal_pkg::SLOTS_CNT) begin
                // fresh slot at generation zero, live
                tbl_req.we      = 1'b1;
                tbl_req.wr_addr = used_q[ghal_pkg::IDX_W-1:0];
                used_d = used_q + 1'b1;
                res_d  = '{status: ghal_pkg::ST_OK,
                           idx: used_q[ghal_pkg::IDX_W-1:0], gen: '0};
              end else begin
                res_d.status = ghal_pkg::ST_FULL;
              end
            end
            ghal_pkg::OP_REMOVE, ghal_pkg::OP_CHECK: begin
              if (in_lt) begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = in_idx;
                state_d = S_CHECK;
              end
            end
            ghal_pkg::OP_FIRST: begin
              ptr_d = '0;
              left_d = used_q;
              up_d = 1'b1;
              state_d = S_SCAN;
            end
            ghal_pkg::OP_NEXT: begin
              ptr_d  = (in_lt && (idx_inc < used_q)) ? idx_inc[ghal_pkg::IDX_W-1:0] : '0;
              left_d = in_lt ? used_q - 1'b1 : used_q;
              up_d   = 1'b1;
              state_d = S_SCAN;
            end
            ghal_pkg::OP_PREV: begin
              ptr_d  = (!in_lt || (in_idx == '0)) ? last : in_idx - 1'b1;
              left_d = in_lt ? used_q - 1'b1 : used_q;
              up_d   = 1'b0;
              state_d = S_SCAN;
            end
            default: begin
              res_d.status = ghal_pkg::ST_INVALID;
            end
          endcase
        end
      end
      S_POP: begin
        // reuse the oldest freed slot
        fifo_req.pop    = 1'b1;
        tbl_req.we      = 1'b1;
        tbl_req.wr_addr = fifo_entry.idx;
        tbl_req.wr_gen  = fifo_entry.gen;
        res_d = '{status: ghal_pkg::ST_OK, idx: fifo_entry.idx, gen: fifo_entry.gen};
        state_d = S_RESP;
      end
      S_CHECK: begin
        res_d = '{status: ghal_pkg::ST_OK, idx: '0, gen: '0};
        if (tbl_gen != gen_q) begin
          res_d.status = ghal_pkg::ST_GEN_MISMATCH;
        end else if (tbl_rem) begin
          res_d.status = ghal_pkg::ST_REMOVED;
        end else if (op_q == ghal_pkg::OP_REMOVE) begin
          // mark removed, keep the generation
          tbl_req.we        = 1'b1;
          tbl_req.wr_addr   = idx_q;
          tbl_req.wr_gen    = tbl_gen;
          tbl_req.wr_rem    = 1'b1;
          fifo_req.push     = 1'b1;
          fifo_req.push_idx = idx_q;
          fifo_req.push_gen = tbl_gen + 1'b1;
        end
        state_d = S_RESP;
      end
      S_SCAN: begin
        // one read issued per cycle, its data checked the cycle after
        if (vld_q && !tbl_rem) begin
          res_d = '{status: ghal_pkg::ST_OK, idx: chk_q, gen: tbl_gen};
          state_d = S_RESP;
        end else if (left_q == '0) begin
          res_d = '{status: ghal_pkg::ST_NONE, idx: '0, gen: '0};
          state_d = S_RESP;
        end else begin
          tbl_req.rd_en   = 1'b1;
          tbl_req.rd_addr = ptr_q;
          chk_d  = ptr_q;
          vld_d  = 1'b1;
          ptr_d  = ptr_step;
          left_d = left_q - 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {5'b0, res_q.gen, res_q.idx, res_q.status};
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      used_q     <= '0;
      vld_q      <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      vld_q      <= vld_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_d_reg: begin
      op_q      <= op_d;
      idx_q     <= idx_d;
      gen_q     <= gen_d;
      ptr_q     <= ptr_d;
      left_q    <= left_d;
      up_q      <= up_d;
      chk_q     <= chk_d;
      res_q     <= res_d;
      m_tdata_q <= m_tdata_d;
    end
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;

`ifndef SYNTH
  // the free queue never holds more entries than there are used slots
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= used_q)
    else $error("free queue holds more slots than in use");

  // the slot count never shrinks
  a_used_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 used_q >= $past(used_q))
    else $error("slots in use decreased");

  // a result in the response state is loaded into the output register once the output is free
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_free) |=> m_tvalid_q && state_q == S_IDLE)
    else $error("response not delivered to output register");
`endif

endmodule

// ===== design/ghal_slot_table.sv =====
// ghal_slot_table: per-slot memory holding the removed mark and generation
// depends on ghal_pkg
module ghal_slot_table (
  input  logic                          clk_i,
  input  ghal_pkg::tbl_req_t            req_i,
  output logic [ghal_pkg::GEN_W-1:0]    rd_gen_o,
  output logic                          rem_o
);

  // entry: removed mark on top, generation below
  logic [ghal_pkg::GEN_W:0] slot_mem [ghal_pkg::SLOTS];
  logic [ghal_pkg::GEN_W:0] rd_q;

  // one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      slot_mem[req_i.wr_addr] <= {req_i.wr_rem, req_i.wr_gen};
    end
    if (req_i.rd_en) begin
      rd_q <= slot_mem[req_i.rd_addr];
    end
  end

  assign rd_gen_o = rd_q[ghal_pkg::GEN_W-1:0];
  assign rem_o    = rd_q[ghal_pkg::GEN_W];

endmodule

// ===== design/ghal_free_fifo.sv =====
// ghal_free_fifo: queue of freed slots with their advanced generations
// depends on ghal_pkg
module ghal_free_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ghal_pkg::fifo_req_t           req_i,
  output ghal_pkg::fifo_entry_t         rd_entry_o,
  output logic [ghal_pkg::CNT_W-1:0]    count_o
);

  ghal_pkg::fifo_entry_t         mem [ghal_pkg::SLOTS];
  ghal_pkg::fifo_entry_t         rd_entry_q;
  logic [ghal_pkg::IDX_W-1:0]    head_q, head_d;
  logic [ghal_pkg::IDX_W-1:0]    tail_q, tail_d;
  logic [ghal_pkg::CNT_W-1:0]    count_q, count_d;
  logic                          push_ok;

  assign push_ok = req_i.push && (count_q != ghal_pkg::SLOTS_CNT);

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[tail_q] <= '{idx: req_i.push_idx, gen: req_i.push_gen};
    end
    if (req_i.rd_en) begin
      rd_entry_q <= mem[head_q];
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (req_i.pop) begin
      head_d = head_q + 1'b1;
    end
    if (push_ok) begin
      tail_d = tail_q + 1'b1;
    end
    if (req_i.pop && !push_ok) begin
      count_d = count_q - 1'b1;
    end else if (push_ok && !req_i.pop) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign count_o    = count_q;

endmodule
